/* sv/job_retry_cooldown_tracker_macros.svh */
// assertion macros for the job retry cooldown tracker
// no dependencies; included by files that carry concurrent assertions
`ifndef JOB_RETRY_COOLDOWN_TRACKER_MACROS_SVH
`define JOB_RETRY_COOLDOWN_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define JRCT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define JRCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define JRCT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define JRCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/jrct_pkg.sv */
// shared types and constants for the job retry cooldown tracker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package jrct_pkg;

    localparam int DATA_W    = 32;
    localparam int STEP_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 168;

    localparam logic [DATA_W-1:0] ROUND_UP_ADD  = 32'd999;
    localparam logic [DATA_W-1:0] MS_PER_S      = 32'd1000;
    localparam logic [DATA_W-1:0] INIT_DELAY_RST = 32'd1000;
    localparam logic [DATA_W-1:0] MAX_DELAY_RST  = 32'd60000;

    // ceil(2^38 / 1000): (x * RECIP_1000) >> 38 equals x / 1000 for every 32-bit x
    localparam int                 RECIP_W     = 29;
    localparam int                 RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_1000  = 29'h10624DD3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RUNNING  = 3'd1,
        PH_READY    = 3'd2,
        PH_FAILED   = 3'd3,
        PH_COOLDOWN = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_SUCCEED = 2'd1,
        CMD_FAIL    = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_DELAY = 1'd0,
        CFG_MAXIMUM_DELAY = 1'd1
    } t_cfg_idx;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ROUND,
        SEQ_DIV,
        SEQ_RETRY,
        SEQ_BLOAD,
        SEQ_BACK,
        SEQ_CLIP,
        SEQ_DONE
    } t_seq_st;

    typedef struct packed {
        logic start;
        logic fail;
    } t_seq_ctl;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] retry_s;
        logic [DATA_W-1:0] delay_ms;
    } t_seq_res;

endpackage

/* sv/jrct_alu.sv */
// shared 32-bit add / subtract unit with carry-borrow out
// depends on jrct_pkg
`timescale 1ns / 1ps

module jrct_alu (
    input  jrct_pkg::t_alu_op               i_op,
    input  logic [jrct_pkg::DATA_W-1:0]     i_a,
    input  logic [jrct_pkg::DATA_W-1:0]     i_b,
    output logic [jrct_pkg::DATA_W-1:0]     o_res,
    output logic                            o_carry
);

    logic [jrct_pkg::DATA_W:0] w_full;

    // for subtraction the top bit is the borrow, set when a < b
    always_comb begin
        if (i_op == jrct_pkg::ALU_ADD) begin
            w_full = {1'b0, i_a} + {1'b0, i_b};
        end else begin
            w_full = {1'b0, i_a} - {1'b0, i_b};
        end
    end

    assign o_res   = w_full[jrct_pkg::DATA_W-1:0];
    assign o_carry = w_full[jrct_pkg::DATA_W];

endmodule

/* sv/jrct_seq.sv */
// sequencer: cooldown round-up, reciprocal divide by 1000, retry sum,
// backoff doubling and clip, the add / compare steps through one shared jrct_alu
// depends on jrct_pkg and jrct_alu
`timescale 1ns / 1ps

module jrct_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jrct_pkg::t_seq_ctl            i_ctl,
    input  logic [jrct_pkg::DATA_W-1:0]   i_cool,
    input  logic [jrct_pkg::DATA_W-1:0]   i_now,
    input  logic [jrct_pkg::DATA_W-1:0]   i_attempts,
    input  logic [jrct_pkg::DATA_W-1:0]   i_init,
    input  logic [jrct_pkg::DATA_W-1:0]   i_max,
    input  logic                          i_out_free,
    output logic                          o_idle,
    output jrct_pkg::t_seq_res            o_res
);

    localparam int DW = jrct_pkg::DATA_W;
    localparam int SW = jrct_pkg::STEP_W;
    localparam int PW = jrct_pkg::DATA_W + jrct_pkg::RECIP_W;

    jrct_pkg::t_seq_st r_state, n_state;
    logic [DW-1:0]     r_work,  n_work;
    logic [DW-1:0]     r_now,   n_now;
    logic [DW-1:0]     r_delay, n_delay;
    logic [DW-1:0]     r_retry, n_retry;
    logic [SW-1:0]     r_step,  n_step;

    jrct_pkg::t_alu_op w_op;
    logic [DW-1:0]     w_a, w_b, w_res;
    logic              w_carry;
    logic [PW-1:0]     w_prod;
    logic [DW-1:0]     w_half;
    logic              w_left;
    logic              w_done;

    jrct_alu u_alu (
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_res   (w_res),
        .o_carry (w_carry)
    );

    assign w_prod = {{jrct_pkg::RECIP_W{1'b0}}, r_work} *
                    {{DW{1'b0}}, jrct_pkg::RECIP_1000};
    assign w_half = {1'b0, i_max[DW-1:1]};
    // doublings left while attempts - 1 > steps taken
    assign w_left = (|i_attempts[DW-1:SW]) || (i_attempts[SW-1:0] > (r_step + SW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jrct_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_now   <= n_now;
        r_delay <= n_delay;
        r_retry <= n_retry;
        r_step  <= n_step;
    end

    always_comb begin
        n_state = r_state;
        n_work  = r_work;
        n_now   = r_now;
        n_delay = r_delay;
        n_retry = r_retry;
        n_step  = r_step;
        w_op    = jrct_pkg::ALU_SUB;
        w_a     = r_delay;
        w_b     = w_half;
        w_done  = 1'b0;
        case (r_state)
            jrct_pkg::SEQ_IDLE: begin
                if (i_ctl.start) begin
                    n_work  = i_cool;
                    n_now   = i_now;
                    n_state = i_ctl.fail ? jrct_pkg::SEQ_ROUND : jrct_pkg::SEQ_BLOAD;
                end
            end
            jrct_pkg::SEQ_ROUND: begin
                w_op    = jrct_pkg::ALU_ADD;
                w_a     = r_work;
                w_b     = jrct_pkg::ROUND_UP_ADD;
                n_work  = w_res;
                n_step  = '0;
                n_state = jrct_pkg::SEQ_DIV;
            end
            jrct_pkg::SEQ_DIV: begin
                // quotient by 1000 from the reciprocal product, top bits only
                n_work  = DW'(w_prod[PW-1:jrct_pkg::RECIP_SHIFT]);
                n_state = jrct_pkg::SEQ_RETRY;
            end
            jrct_pkg::SEQ_RETRY: begin
                w_op    = jrct_pkg::ALU_ADD;
                w_a     = r_now;
                w_b     = r_work;
                n_retry = w_res;
                n_state = jrct_pkg::SEQ_BLOAD;
            end
            jrct_pkg::SEQ_BLOAD: begin
                n_delay = i_init;
                n_step  = '0;
                n_state = jrct_pkg::SEQ_BACK;
            end
            jrct_pkg::SEQ_BACK: begin
                // borrow means delay below half the maximum
                w_op = jrct_pkg::ALU_SUB;
                w_a  = r_delay;
                w_b  = w_half;
                if (w_left && (r_delay != '0) && w_carry) begin
                    n_delay = {r_delay[DW-2:0], 1'b0};
                    n_step  = r_step + SW'(1);
                end else begin
                    n_state = jrct_pkg::SEQ_CLIP;
                end
            end
            jrct_pkg::SEQ_CLIP: begin
                w_op = jrct_pkg::ALU_SUB;
                w_a  = i_max;
                w_b  = r_delay;
                if (w_carry) begin
                    n_delay = i_max;
                end
                n_state = jrct_pkg::SEQ_DONE;
            end
            jrct_pkg::SEQ_DONE: begin
                if (i_out_free) begin
                    w_done  = 1'b1;
                    n_state = jrct_pkg::SEQ_IDLE;
                end
            end
            default: begin
                n_state = jrct_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign o_idle         = (r_state == jrct_pkg::SEQ_IDLE);
    assign o_res.done     = w_done;
    assign o_res.retry_s  = r_retry;
    assign o_res.delay_ms = r_delay;

endmodule

/* sv/job_retry_cooldown_tracker.sv */
// top level of the job retry cooldown tracker: job state, configuration,
// stream ports and result register; depends on jrct_pkg, jrct_seq and the macros header
//
//   channel  direction  handshake                 payload
//   s        in         i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser (event)
//   m        out        o_m_tvalid / i_m_tready   o_m_tdata (job snapshot)
//   cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// succeed, begin and query transfers step the sequencer through the backoff load, the
// backoff doublings (0 to 31) and the clip to the result; a fail transfer first runs the
// round-up, the reciprocal multiply by 1/1000 and the retry sum
// one event at a time: o_s_tready is low from the accepting edge until the result
// has moved into the output register, which frees while it waits to be taken
// synchronous active-low reset; o_cfg_ready is always high
`timescale 1ns / 1ps
`include "job_retry_cooldown_tracker_macros.svh"

module job_retry_cooldown_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // event channel
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] time_now_s, [63:32] error_code, [95:64] cool_len_ms
    input  logic [jrct_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // [1:0] cmd
    input  logic [jrct_pkg::S_TUSER_W-1:0]      i_s_tuser,
    // snapshot channel
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] accepted, [3:1] job_state, [35:4] attempt_total, [67:36] updated_time_s,
    // [99:68] retry_time_s, [131:100] stored_error, [163:132] backoff_delay_ms,
    // [167:164] zero
    output logic [jrct_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jrct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jrct_pkg::DATA_W-1:0]         i_cfg_data
);

    localparam int DW = jrct_pkg::DATA_W;

    // configuration registers
    logic [DW-1:0]        r_init, r_max;

    // job state
    jrct_pkg::t_phase     r_phase;
    logic [DW-1:0]        r_attempts;
    logic [DW-1:0]        r_upd;
    logic [DW-1:0]        r_retry;
    logic signed [DW-1:0] r_err;
    logic                 r_acc;
    logic                 r_fail;

    // result register
    logic                          r_m_tvalid;
    logic [jrct_pkg::M_TDATA_W-1:0] r_m_tdata;

    // unpacked event fields
    jrct_pkg::t_cmd       w_cmd;
    logic [DW-1:0]        w_now;
    logic signed [DW-1:0] w_err_in;
    logic [DW-1:0]        w_cool;

    logic                 w_accept;
    logic                 w_begin_ok;
    logic                 w_seq_idle;
    logic                 w_out_free;
    logic [DW-1:0]        w_retry_out;
    jrct_pkg::t_seq_ctl   w_ctl;
    jrct_pkg::t_seq_res   w_res;

    assign w_cmd    = jrct_pkg::t_cmd'(i_s_tuser);
    assign w_now    = i_s_tdata[31:0];
    assign w_err_in = i_s_tdata[63:32];
    assign w_cool   = i_s_tdata[95:64];

    assign o_s_tready = w_seq_idle;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    // begin refused while running, or in cooldown before the retry time
    assign w_begin_ok = (r_phase != jrct_pkg::PH_RUNNING) &&
                        ((r_phase != jrct_pkg::PH_COOLDOWN) || (w_now >= r_retry));

    assign w_ctl.start = w_accept;
    assign w_ctl.fail  = (w_cmd == jrct_pkg::CMD_FAIL);

    jrct_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cool     (w_cool),
        .i_now      (w_now),
        .i_attempts (r_attempts),
        .i_init     (r_init),
        .i_max      (r_max),
        .i_out_free (w_out_free),
        .o_idle     (w_seq_idle),
        .o_res      (w_res)
    );

    // configuration writes, taken every cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= jrct_pkg::INIT_DELAY_RST;
            r_max  <= jrct_pkg::MAX_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                jrct_pkg::CFG_INITIAL_DELAY: r_init <= i_cfg_data;
                jrct_pkg::CFG_MAXIMUM_DELAY: r_max  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // job state update at the accepting edge; a fail's retry time lands
    // when the sequencer delivers its result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= jrct_pkg::PH_IDLE;
            r_attempts <= '0;
            r_upd      <= '0;
            r_retry    <= '0;
            r_err      <= '0;
            r_acc      <= 1'b0;
            r_fail     <= 1'b0;
        end else if (w_accept) begin
            r_acc  <= 1'b0;
            r_fail <= 1'b0;
            case (w_cmd)
                jrct_pkg::CMD_BEGIN: begin
                    if (w_begin_ok) begin
                        r_phase    <= jrct_pkg::PH_RUNNING;
                        r_attempts <= r_attempts + DW'(1);
                        r_upd      <= w_now;
                        r_err      <= '0;
                        r_acc      <= 1'b1;
                    end
                end
                jrct_pkg::CMD_SUCCEED: begin
                    r_phase <= jrct_pkg::PH_READY;
                    r_upd   <= w_now;
                    r_retry <= '0;
                    r_err   <= '0;
                end
                jrct_pkg::CMD_FAIL: begin
                    r_phase <= (w_cool != '0) ? jrct_pkg::PH_COOLDOWN : jrct_pkg::PH_FAILED;
                    r_upd   <= w_now;
                    r_err   <= w_err_in;
                    r_fail  <= 1'b1;
                end
                default: begin
                    // query leaves the job untouched
                end
            endcase
        end else if (w_res.done && r_fail) begin
            r_retry <= w_res.retry_s;
        end
    end

    assign w_retry_out = r_fail ? w_res.retry_s : r_retry;

    // result register parts the sequencer from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_res.done) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            r_m_tdata <= {4'b0000, w_res.delay_ms, r_err, w_retry_out, r_upd,
                          r_attempts, r_phase, r_acc};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // an accepted event keeps the input side closed in the following cycle
    `JRCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_tready)
    // a finished result never overwrites one that is still waiting
    `JRCT_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_res.done, w_out_free)
    // an accepted begin runs the job and counts exactly one attempt
    `JRCT_ASSERT_NEXT(a_begin_counts, i_clk, i_rst_n,
        w_accept && (w_cmd == jrct_pkg::CMD_BEGIN) && w_begin_ok,
        (r_phase == jrct_pkg::PH_RUNNING) && (r_attempts == $past(r_attempts) + DW'(1)))

endmodule

/* sim/tb_top.sv */
// self-checking bench for the job retry cooldown tracker: directed lifecycle,
// backoff limits, random traffic; depends on jrct_pkg and job_retry_cooldown_tracker
// every snapshot is checked against a cycle-free job model
`timescale 1ns / 1ps

module tb_top;
    import jrct_pkg::*;

    // one snapshot as it leaves the block
    typedef struct {
        logic              accepted;
        t_phase            job_state;
        logic [31:0]       attempts;
        logic [31:0]       changed_s;
        logic [31:0]       retry_s;
        logic signed [31:0] error_code;
        logic [31:0]       delay_ms;
    } job_snapshot_t;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // [31:0] time_now_s, [63:32] error_code, [95:64] cool_len_ms
    logic [S_TUSER_W-1:0]  s_tuser = '0;   // [1:0] cmd

    logic                  o_m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;      // accepted, state, attempts, updated, retry, error, delay

    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              cfg_index = CFG_INITIAL_DELAY;
    logic [31:0]           cfg_data = '0;

    job_retry_cooldown_tracker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // job model: its own copy of the tracked job and of the backoff limits
    t_phase             job_phase     = PH_IDLE;
    logic [31:0]        attempt_cnt   = '0;
    logic [31:0]        last_change_s = '0;
    logic [31:0]        retry_at_s    = '0;
    logic signed [31:0] err_latch     = '0;
    logic [31:0]        model_initial = INIT_DELAY_RST;
    logic [31:0]        model_maximum = MAX_DELAY_RST;

    job_snapshot_t pending_snapshots[$];

    int n_events         = 0;
    int n_checked        = 0;
    int n_begins_taken   = 0;
    int n_begins_refused = 0;
    int n_fails          = 0;
    int n_reg_writes     = 0;
    int mismatches       = 0;
    int burst_left       = 0;
    int stall_mode       = 0;
    int stall_run        = 0;
    int stall_tick       = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout: %0d snapshots still outstanding", pending_snapshots.size());
        $display("CHECK FAILED");
        $finish;
    end

    // delay doubles from the initial value once per attempt after the first while below half the maximum, then clipped
    function automatic logic [31:0] backoff_for_attempts(logic [31:0] attempts,
                                                         logic [31:0] init_ms,
                                                         logic [31:0] max_ms);
        logic [31:0] delay;
        logic [31:0] doublings_left;
        logic [31:0] half_max;
        delay          = init_ms;
        doublings_left = (attempts > 32'd1) ? attempts - 32'd1 : 32'd0;
        half_max       = max_ms >> 1;
        while (doublings_left != 0 && delay != 0 && delay < half_max) begin
            delay = delay << 1;
            doublings_left--;
        end
        return (delay > max_ms) ? max_ms : delay;
    endfunction

    // apply one event to the job model and return the snapshot it should produce
    function automatic job_snapshot_t job_model_step(t_cmd cmd, logic [31:0] now_s,
                                                     logic [31:0] err, logic [31:0] cool_ms);
        job_snapshot_t snap;
        logic [31:0]   rounded_ms;
        snap.accepted = 1'b0;
        rounded_ms    = cool_ms + ROUND_UP_ADD;   // wraps like the 32-bit sum it models
        case (cmd)
            CMD_BEGIN: begin
                // refused while running, or in cooldown before the retry time
                if (job_phase != PH_RUNNING && (job_phase != PH_COOLDOWN || now_s >= retry_at_s)) begin
                    job_phase     = PH_RUNNING;
                    attempt_cnt   = attempt_cnt + 32'd1;
                    last_change_s = now_s;
                    err_latch     = '0;
                    snap.accepted = 1'b1;
                    n_begins_taken++;
                end else begin
                    n_begins_refused++;
                end
            end
            CMD_SUCCEED: begin
                job_phase     = PH_READY;
                last_change_s = now_s;
                retry_at_s    = '0;
                err_latch     = '0;
            end
            CMD_FAIL: begin
                if (cool_ms != 0) begin
                    job_phase = PH_COOLDOWN;
                end else begin
                    job_phase = PH_FAILED;
                end
                last_change_s = now_s;
                retry_at_s    = now_s + rounded_ms / MS_PER_S;
                err_latch     = err;
                n_fails++;
            end
            default: ;   // query leaves the job alone
        endcase
        snap.job_state  = job_phase;
        snap.attempts   = attempt_cnt;
        snap.changed_s  = last_change_s;
        snap.retry_s    = retry_at_s;
        snap.error_code = err_latch;
        snap.delay_ms   = backoff_for_attempts(attempt_cnt, model_initial, model_maximum);
        return snap;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch on %s at snapshot %0d: got %h, wanted %h",
                     what, n_checked, got, want);
        end
    endtask

    // compare one snapshot transfer against the oldest outstanding prediction
    task automatic check_snapshot();
        job_snapshot_t got;
        job_snapshot_t want;
        got.accepted   = o_m_tdata[0];
        got.job_state  = t_phase'(o_m_tdata[3:1]);
        got.attempts   = o_m_tdata[35:4];
        got.changed_s  = o_m_tdata[67:36];
        got.retry_s    = o_m_tdata[99:68];
        got.error_code = o_m_tdata[131:100];
        got.delay_ms   = o_m_tdata[163:132];
        n_checked++;
        if (pending_snapshots.size() == 0) begin
            report_mismatch("unexpected snapshot", got.attempts, '0);
            return;
        end
        want = pending_snapshots.pop_front();
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.job_state !== want.job_state)
            report_mismatch("job_state", 32'(got.job_state), 32'(want.job_state));
        if (got.attempts !== want.attempts)
            report_mismatch("attempt_total", got.attempts, want.attempts);
        if (got.changed_s !== want.changed_s)
            report_mismatch("updated_time_s", got.changed_s, want.changed_s);
        if (got.retry_s !== want.retry_s)
            report_mismatch("retry_time_s", got.retry_s, want.retry_s);
        if (got.error_code !== want.error_code)
            report_mismatch("stored_error", got.error_code, want.error_code);
        if (got.delay_ms !== want.delay_ms)
            report_mismatch("backoff_delay_ms", got.delay_ms, want.delay_ms);
        if (o_m_tdata[167:164] !== 4'd0)
            report_mismatch("padding", 32'(o_m_tdata[167:164]), '0);
    endtask

    // snapshot side: check on each transfer, then pick the next tready from a changing pattern
    always @(posedge i_clk) begin
        if (rst_n && o_m_tvalid && m_tready) begin
            check_snapshot();
        end
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 300);
        end
        stall_run--;
        stall_tick++;
        case (stall_mode)
            0:       m_tready <= 1'b1;                      // no back-pressure
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_tick % 5) == 0;
            default: m_tready <= (stall_tick % 32) >= 24;   // long holds
        endcase
    end

    // one event transfer; bursts keep tvalid high, a new burst may open with a gap
    task automatic send_event(input t_cmd cmd, input logic [31:0] now_s,
                              input logic [31:0] err, input logic [31:0] cool_ms);
        int            gap;
        job_snapshot_t snap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cool_ms, err, now_s};
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        snap = job_model_step(cmd, now_s, err, cool_ms);
        pending_snapshots.push_back(snap);
        n_events++;
    endtask

    // called at the edge of a transfer; returns once every snapshot has been taken
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_snapshots.size() != 0);
    endtask

    // both limit registers back to back, valid held high across the pair
    task automatic set_backoff_limits(input logic [31:0] init_ms, input logic [31:0] max_ms);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INITIAL_DELAY;
        cfg_data  <= init_ms;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_initial = init_ms;
        cfg_index <= CFG_MAXIMUM_DELAY;
        cfg_data  <= max_ms;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_maximum = max_ms;
        cfg_valid <= 1'b0;
        n_reg_writes += 2;
    endtask

    // mostly well-formed begin / outcome cycles with random content, some noise
    task automatic run_job_traffic(input int count);
        logic [31:0] wall_s;
        logic [31:0] now_s;
        logic [31:0] err;
        logic [31:0] cool_ms;
        t_cmd        cmd;
        int          pick;
        wall_s = $urandom;
        for (int i = 0; i < count; i++) begin
            pick   = $urandom_range(0, 99);
            now_s  = wall_s + $urandom_range(0, 3);
            err    = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
            case ($urandom_range(0, 9))
                0:       cool_ms = 32'd0;
                1:       cool_ms = 32'hFFFF_FFFF - $urandom_range(0, 1100);
                2:       cool_ms = $urandom;
                default: cool_ms = $urandom_range(1, 9000);
            endcase
            if (pick < 12) begin
                cmd     = t_cmd'($urandom_range(0, 3));
                now_s   = $urandom;
                cool_ms = $urandom;
            end else if (job_phase == PH_RUNNING) begin
                cmd = (pick < 70) ? CMD_FAIL : (pick < 92) ? CMD_SUCCEED : CMD_QUERY;
            end else begin
                cmd = (pick < 86) ? CMD_BEGIN : (pick < 93) ? CMD_QUERY : CMD_SUCCEED;
                // land begins just around the retry time
                if (job_phase == PH_COOLDOWN && cmd == CMD_BEGIN) begin
                    now_s = retry_at_s + $urandom_range(0, 4) - 32'd2;
                end
            end
            wall_s = now_s;
            send_event(cmd, now_s, err, cool_ms);
            // now and then hold off until the block has drained
            if ($urandom_range(0, 49) == 0) begin
                wait_until_idle();
            end
        end
    endtask

    // directed walk through every phase and each corner of the retry rules
    task automatic test_job_lifecycle();
        send_event(CMD_QUERY,   32'd0,          32'd0,          32'd0);          // reset snapshot
        send_event(CMD_BEGIN,   32'd10,         32'd0,          32'd0);          // from idle
        send_event(CMD_BEGIN,   32'd11,         32'd0,          32'd0);          // refused, running
        send_event(CMD_FAIL,    32'd12,         32'h7FFF_FFFF,  32'd0);          // permanent failure
        send_event(CMD_BEGIN,   32'd0,          32'd0,          32'd0);          // failed allows any time
        send_event(CMD_FAIL,    32'd100,        32'h8000_0000,  32'd5000);
        send_event(CMD_BEGIN,   32'd104,        32'd0,          32'd0);          // one second early
        send_event(CMD_QUERY,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_event(CMD_BEGIN,   32'd105,        32'd0,          32'd0);          // exactly on time
        send_event(CMD_FAIL,    32'd200,        32'hFFFF_FFFF,  32'd1);          // rounds up to a second
        send_event(CMD_BEGIN,   32'd201,        32'd0,          32'd0);
        send_event(CMD_FAIL,    32'd300,        32'd5,          32'hFFFF_FFFF);  // round-up wraps, adds zero seconds
        send_event(CMD_BEGIN,   32'd299,        32'd0,          32'd0);
        send_event(CMD_BEGIN,   32'd300,        32'd0,          32'd0);
        send_event(CMD_FAIL,    32'hFFFF_FFFE,  32'd0,          32'd4_000_000);  // retry time wraps
        send_event(CMD_BEGIN,   32'hFFFF_FFFF,  32'd0,          32'd0);
        send_event(CMD_SUCCEED, 32'd0,          32'd0,          32'd0);
        send_event(CMD_BEGIN,   32'd0,          32'd0,          32'd0);          // from ready
        send_event(CMD_FAIL,    32'd1000,       32'hFFFF_FFFE,  32'd998);
        send_event(CMD_BEGIN,   32'd1001,       32'd0,          32'd0);
        send_event(CMD_FAIL,    32'd7,          32'd3,          32'hFFFF_FC19);  // sum lands on zero
        send_event(CMD_BEGIN,   32'd6,          32'd0,          32'd0);
        send_event(CMD_SUCCEED, 32'd8,          32'd0,          32'd0);          // out of cooldown
        send_event(CMD_SUCCEED, 32'd9,          32'd0,          32'd0);
        send_event(CMD_QUERY,   $urandom,       $urandom,       $urandom);
        wait_until_idle();
    endtask

    // zero initial, tiny limits, clip to zero, long doubling chain, all ones
    task automatic test_backoff_extremes();
        logic [31:0] init_set[5] = '{32'd0, 32'd7, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF};
        logic [31:0] max_set[5]  = '{32'd60000, 32'd100, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        for (int k = 0; k < 5; k++) begin
            set_backoff_limits(init_set[k], max_set[k]);
            run_job_traffic(65);
            wait_until_idle();
        end
    endtask

    task automatic test_random_limits();
        for (int k = 0; k < 2; k++) begin
            set_backoff_limits($urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 16));
            run_job_traffic(50);
            wait_until_idle();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_job_lifecycle();
        test_backoff_extremes();
        test_random_limits();

        // let any stray snapshot show itself before the verdict
        s_tvalid <= 1'b0;
        while (pending_snapshots.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("covered %0d events: %0d begins taken, %0d refused, %0d failures",
                 n_events, n_begins_taken, n_begins_refused, n_fails);
        $display("%0d snapshots compared over %0d limit register writes, %0d mismatches",
                 n_checked, n_reg_writes, mismatches);
        if (mismatches == 0 && pending_snapshots.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
